// ===== hw/rtl/slpd_pkg.sv =====
// Shared constants, codes and types for the status LED pattern driver.
// Used by slpd_lane, the top module and the testbench; depends on nothing.
package slpd_pkg;

  // Default number of LEDs driven
  localparam int LED_COUNT = 10;

  // Field widths
  localparam int MODE_W     = 3;
  localparam int TARGET_W   = 20;
  localparam int LEVEL_W    = 10;
  localparam int PHASE_W    = 8;
  localparam int ROUND_W    = 8;
  localparam int CHASE_W    = 4;
  localparam int CODE_W     = 2;
  localparam int LANE_IDX_W = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // LEDs that have a code in the target field
  localparam int TARGET_LEDS = TARGET_W / CODE_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUNDS_TARGET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHASE_LENGTH  = 2'd2;

  // Configuration reset values
  localparam logic [PHASE_W-1:0] CYCLE_LENGTH_RST  = 8'd10;
  localparam logic [ROUND_W-1:0] ROUNDS_TARGET_RST = 8'd10;
  localparam logic [CHASE_W-1:0] CHASE_LENGTH_RST  = 4'd10;

  // System modes
  localparam logic [MODE_W-1:0] MODE_RESET   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SYNC    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PARTIAL = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ERROR   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READY   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_IDLE    = 3'd5;

  // Per-LED target codes
  localparam logic [CODE_W-1:0] CODE_OFF   = 2'd0;
  localparam logic [CODE_W-1:0] CODE_ON    = 2'd1;
  localparam logic [CODE_W-1:0] CODE_BLINK = 2'd2;
  localparam logic [CODE_W-1:0] CODE_HOLD  = 2'd3;

  // Per-tick control shared by all LED lanes
  typedef struct packed {
    logic               sync_mode;
    logic               err_mode;
    logic               ready_apply;
    logic               wrap;
    logic               done;
    logic               blink;
    logic [CHASE_W-1:0] last_pos;
    logic [CHASE_W-1:0] next_pos;
  } lane_ctl_t;

endpackage

// ===== hw/rtl/slpd_rem.sv =====
// Bit-serial restoring remainder unit, one numerator bit per cycle.
// Depends on nothing but its width parameter.
module slpd_rem #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         busy,
  output logic [W-1:0] rem
);

  localparam int CNT_W = $clog2(W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]     num_r, num_nxt;
  logic [W-1:0]     den_r, den_nxt;
  logic [W-1:0]     rem_r, rem_nxt;
  logic [W:0]       trial;

  // Shift in the next numerator bit and subtract when it fits
  always_comb begin
    trial   = {rem_r, num_r[W-1]};
    cnt_nxt = cnt_r;
    num_nxt = num_r;
    den_nxt = den_r;
    rem_nxt = rem_r;
    if (start) begin
      den_nxt = den;
      if (den == '0) begin
        // zero divisor leaves the value as it is
        rem_nxt = num;
        cnt_nxt = '0;
      end else begin
        rem_nxt = '0;
        num_nxt = num;
        cnt_nxt = CNT_W'(W);
      end
    end else if (cnt_r != '0) begin
      num_nxt = {num_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = W'(trial - {1'b0, den_r});
      end else begin
        rem_nxt = W'(trial);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign busy = (cnt_r != '0);
  assign rem  = rem_r;

endmodule

// ===== hw/rtl/slpd_lane.sv =====
// One LED lane: next level of a single LED for the current tick.
// Depends on slpd_pkg for codes and the lane control struct.
module slpd_lane #(
  parameter int LANE = 0
) (
  input  slpd_pkg::lane_ctl_t               ctl,
  input  logic [slpd_pkg::CODE_W-1:0]       code,
  input  logic                              cur,
  output logic                              nxt
);

  localparam logic [slpd_pkg::LANE_IDX_W-1:0] IDX = slpd_pkg::LANE_IDX_W'(LANE);

  logic is_last;
  logic is_next;

  assign is_last = ({1'b0, ctl.last_pos} == IDX);
  assign is_next = ({1'b0, ctl.next_pos} == IDX);

  // Pick the level for this LED from the mode of the tick
  always_comb begin
    nxt = cur;
    if (ctl.sync_mode) begin
      // drop the old chase LED, then toggle the new one
      if (ctl.wrap && is_last) nxt = 1'b0;
      if (ctl.wrap && is_next) nxt = ~nxt;
      if (ctl.done && (IDX == '0)) nxt = 1'b0;
    end else if (ctl.err_mode) begin
      if (ctl.wrap) nxt = ~cur;
    end else if (ctl.ready_apply) begin
      case (code)
        slpd_pkg::CODE_OFF:   nxt = 1'b0;
        slpd_pkg::CODE_ON:    nxt = 1'b1;
        slpd_pkg::CODE_BLINK: nxt = ctl.blink;
        slpd_pkg::CODE_HOLD:  nxt = cur;
        default:              nxt = cur;
      endcase
    end
  end

endmodule

// ===== hw/rtl/status_led_pattern_driver_top.sv =====
// Status LED pattern driver: tick control, LED lanes and result register.
// Depends on slpd_pkg, slpd_rem and slpd_lane.
//
//   Input channel (in_valid / in_stall) carries one tick: in_mode and
//   in_led_targets. Each accepted tick yields exactly one result on the
//   output channel (out_valid / out_stall): out_led_levels and out_sync_done.
//   A tick transfers when valid is high and stall is low.
//   The result of an accepted tick is registered and shown in the cycle after
//   it is accepted. Throughput is one tick per cycle while in_stall is low;
//   all LED lanes update together; the result register frees as it is taken.
//   When the receiver stalls with a result held, in_stall rises and the
//   held result stays unchanged until taken.
//   Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) is always
//   ready. A write of cycle_length or chase_length starts a bit-serial
//   re-alignment of the phase and chase counters; in_stall is high while it
//   runs. A counter whose divisor (the written value, else the length in
//   force) is zero keeps its next value and adds no stall.
//   Synchronous reset (rst_n low) restores the register defaults
//   (10, 10, 10), clears all counters, turns all LEDs off and empties the
//   result register.
module status_led_pattern_driver_top #(
  parameter int LED_COUNT = slpd_pkg::LED_COUNT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [slpd_pkg::MODE_W-1:0]       in_mode,
  input  logic [slpd_pkg::TARGET_W-1:0]     in_led_targets,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [slpd_pkg::LEVEL_W-1:0]      out_led_levels,
  output logic                              out_sync_done,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [slpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [slpd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int PW = slpd_pkg::PHASE_W;
  localparam int RW = slpd_pkg::ROUND_W;
  localparam int CW = slpd_pkg::CHASE_W;

  // Configuration registers
  logic [PW-1:0] cl_r;
  logic [RW-1:0] rt_r;
  logic [CW-1:0] chl_r;

  // Tick state
  logic [PW-1:0]                   phase_r, phase_nxt;
  logic [RW-1:0]                   round_r, round_nxt;
  logic [CW-1:0]                   chase_r, chase_nxt;
  logic [LED_COUNT-1:0]            led_r, led_nxt;
  logic [slpd_pkg::TARGET_W-1:0]   latched_r, latched_nxt;
  logic                            pre_ph_r, pre_ch_r;

  // Result register
  logic                            out_valid_r;
  logic [slpd_pkg::LEVEL_W-1:0]    out_led_r;
  logic                            out_done_r;

  logic                            cfg_wr;
  logic                            realign;
  logic                            ph_busy, ch_busy, busy;
  logic [PW-1:0]                   ph_rem, ph_den;
  logic [CW-1:0]                   ch_rem, ch_den;
  logic                            in_acc;

  logic [PW:0]                     ph_inc;
  logic [PW-1:0]                   ph;
  logic [CW:0]                     ch_inc;
  logic [CW-1:0]                   ch_next;
  logic                            sync_mode;
  logic                            wrap;
  logic [RW-1:0]                   rc_inc;
  logic                            done;
  logic                            tgt_new;
  slpd_pkg::lane_ctl_t             ctl;
  logic [slpd_pkg::LEVEL_W-1:0]    lvl_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;
  assign realign   = cfg_wr && ((cfg_index == slpd_pkg::CFG_CYCLE_LENGTH) ||
                                (cfg_index == slpd_pkg::CFG_CHASE_LENGTH));

  // Divisors follow the value being written
  assign ph_den = (cfg_index == slpd_pkg::CFG_CYCLE_LENGTH) ? cfg_data : cl_r;
  assign ch_den = (cfg_index == slpd_pkg::CFG_CHASE_LENGTH) ? cfg_data[CW-1:0] : chl_r;

  // Re-align the next phase and next chase position to new lengths
  slpd_rem #(.W(PW)) u_ph_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .start (realign),
    .num   (PW'(phase_r + 1'b1)),
    .den   (ph_den),
    .busy  (ph_busy),
    .rem   (ph_rem)
  );

  slpd_rem #(.W(CW)) u_ch_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .start (realign),
    .num   (CW'(chase_r + 1'b1)),
    .den   (ch_den),
    .busy  (ch_busy),
    .rem   (ch_rem)
  );

  assign busy     = ph_busy | ch_busy;
  assign in_stall = busy | (out_valid_r & out_stall);
  assign in_acc   = in_valid & ~in_stall;

  // Advance the phase, wrapping at the cycle length
  always_comb begin
    ph_inc = {1'b0, phase_r} + 1'b1;
    if (pre_ph_r) begin
      ph = ph_rem;
    end else if ((cl_r != '0) && (ph_inc == {1'b0, cl_r})) begin
      ph = '0;
    end else begin
      ph = ph_inc[PW-1:0];
    end
  end

  // Next chase position, wrapping at the chase length
  always_comb begin
    ch_inc = {1'b0, chase_r} + 1'b1;
    if (pre_ch_r) begin
      ch_next = ch_rem;
    end else if ((chl_r != '0) && (ch_inc == {1'b0, chl_r})) begin
      ch_next = '0;
    end else begin
      ch_next = ch_inc[CW-1:0];
    end
  end

  // Tick control shared by all lanes
  always_comb begin
    sync_mode = (in_mode inside {slpd_pkg::MODE_SYNC, slpd_pkg::MODE_PARTIAL});
    wrap      = (ph == '0);
    rc_inc    = (sync_mode && wrap) ? RW'(round_r + 1'b1) : round_r;
    done      = sync_mode && (rc_inc == rt_r);
    tgt_new   = (in_mode == slpd_pkg::MODE_READY) && (in_led_targets != latched_r);

    ctl.sync_mode   = sync_mode;
    ctl.err_mode    = (in_mode == slpd_pkg::MODE_ERROR);
    ctl.ready_apply = (in_mode == slpd_pkg::MODE_READY) && !tgt_new;
    ctl.wrap        = wrap;
    ctl.done        = done;
    ctl.blink       = (ph < (cl_r >> 1));
    ctl.last_pos    = chase_r;
    ctl.next_pos    = ch_next;

    phase_nxt   = ph;
    round_nxt   = sync_mode ? (done ? '0 : rc_inc) : round_r;
    chase_nxt   = (sync_mode && wrap) ? ch_next : chase_r;
    latched_nxt = tgt_new ? in_led_targets : latched_r;
  end

  // One lane per LED
  for (genvar g = 0; g < LED_COUNT; g++) begin : g_lane
    logic [slpd_pkg::CODE_W-1:0] code;
    if (g < slpd_pkg::TARGET_LEDS) begin : g_code
      assign code = latched_r[slpd_pkg::CODE_W*g +: slpd_pkg::CODE_W];
    end else begin : g_nocode
      assign code = slpd_pkg::CODE_OFF;
    end
    slpd_lane #(.LANE(g)) u_lane (
      .ctl  (ctl),
      .code (code),
      .cur  (led_r[g]),
      .nxt  (led_nxt[g])
    );
  end

  // Merge lane levels into the output field
  for (genvar k = 0; k < slpd_pkg::LEVEL_W; k++) begin : g_lvl
    if (k < LED_COUNT) begin : g_led
      assign lvl_nxt[k] = led_nxt[k];
    end else begin : g_none
      assign lvl_nxt[k] = 1'b0;
    end
  end

  // Configuration and tick state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cl_r      <= slpd_pkg::CYCLE_LENGTH_RST;
      rt_r      <= slpd_pkg::ROUNDS_TARGET_RST;
      chl_r     <= slpd_pkg::CHASE_LENGTH_RST;
      phase_r   <= '0;
      round_r   <= '0;
      chase_r   <= '0;
      led_r     <= '0;
      latched_r <= '0;
      pre_ph_r  <= 1'b0;
      pre_ch_r  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          slpd_pkg::CFG_CYCLE_LENGTH:  cl_r  <= cfg_data;
          slpd_pkg::CFG_ROUNDS_TARGET: rt_r  <= cfg_data;
          slpd_pkg::CFG_CHASE_LENGTH:  chl_r <= cfg_data[CW-1:0];
          default: ;
        endcase
      end
      if (realign) begin
        pre_ph_r <= 1'b1;
        pre_ch_r <= 1'b1;
      end else if (in_acc) begin
        phase_r   <= phase_nxt;
        round_r   <= round_nxt;
        chase_r   <= chase_nxt;
        led_r     <= led_nxt;
        latched_r <= latched_nxt;
        pre_ph_r  <= 1'b0;
        if (sync_mode && wrap) pre_ch_r <= 1'b0;
      end
    end
  end

  // Result register: load on transfer in, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (in_acc) begin
      out_led_r  <= lvl_nxt;
      out_done_r <= done;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_led_levels = out_led_r;
  assign out_sync_done  = out_done_r;

  // Checks
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> in_stall)
    else $error("input accepted during re-alignment");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid)
    else $error("accepted tick produced no result");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    (!pre_ph_r && (cl_r != '0)) |-> (phase_r < cl_r))
    else $error("phase counter beyond cycle length");

  a_chase_range: assert property (@(posedge clk) disable iff (!rst_n)
    (!pre_ch_r && (chl_r != '0)) |-> (chase_r < chl_r))
    else $error("chase position beyond chase length");

endmodule

// ===== verif/status_led_pattern_driver_top_tb.sv =====
// Testbench for status_led_pattern_driver_top: random and directed ticks,
// register sweeps and back-pressure, checked against an in-bench predictor.
// Depends on slpd_pkg and the RTL under hw/rtl.
`timescale 1ns / 100ps

module status_led_pattern_driver_top_tb;

  // Modes outside the named set behave like idle
  localparam logic [slpd_pkg::MODE_W-1:0] MODE_SPARE6 = 3'd6;
  localparam logic [slpd_pkg::MODE_W-1:0] MODE_SPARE7 = 3'd7;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [slpd_pkg::LEVEL_W-1:0] levels;
    logic                         done;
  } led_result_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  logic [slpd_pkg::MODE_W-1:0]     in_mode;
  logic [slpd_pkg::TARGET_W-1:0]   in_led_targets;
  logic                            out_valid;
  logic                            out_stall;
  logic [slpd_pkg::LEVEL_W-1:0]    out_led_levels;
  logic                            out_sync_done;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [slpd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [slpd_pkg::CFG_DATA_W-1:0] cfg_data;

  status_led_pattern_driver_top uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_led_targets (in_led_targets),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_led_levels (out_led_levels),
    .out_sync_done  (out_sync_done),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Predicted block state and register copies
  logic [slpd_pkg::PHASE_W-1:0]   pred_phase;
  logic [slpd_pkg::ROUND_W-1:0]   pred_rounds;
  logic [slpd_pkg::CHASE_W-1:0]   pred_chase;
  logic [slpd_pkg::LED_COUNT-1:0] pred_leds;
  logic [slpd_pkg::TARGET_W-1:0]  pred_latched;
  logic [slpd_pkg::PHASE_W-1:0]   pred_cycle_len;
  logic [slpd_pkg::ROUND_W-1:0]   pred_round_goal;
  logic [slpd_pkg::CHASE_W-1:0]   pred_chase_len;

  led_result_t levels_due[$];

  int  fault_count;
  int  tick_count;
  int  result_count;
  int  done_count;
  int  cfg_count;
  int  hold_cycles;
  bit  sender_eager;
  bit  receiver_eager;
  logic [slpd_pkg::TARGET_W-1:0] ready_pattern;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Advance the predicted LED state by one tick
  function automatic led_result_t advance_leds(
      input logic [slpd_pkg::MODE_W-1:0] mode,
      input logic [slpd_pkg::TARGET_W-1:0] targets);
    led_result_t                  r;
    logic [slpd_pkg::PHASE_W-1:0] ph;
    logic [slpd_pkg::CHASE_W-1:0] last;
    logic [slpd_pkg::CHASE_W-1:0] nxt;
    logic                         blink;
    logic [slpd_pkg::CODE_W-1:0]  code;
    r.done = 1'b0;
    ph = pred_phase + 8'd1;
    if (pred_cycle_len != 0) ph = ph % pred_cycle_len;
    pred_phase = ph;
    if (mode == slpd_pkg::MODE_SYNC || mode == slpd_pkg::MODE_PARTIAL) begin
      if (ph == 0) begin
        last = pred_chase;
        nxt = last + 4'd1;
        if (pred_chase_len != 0) nxt = nxt % pred_chase_len;
        pred_chase = nxt;
        // positions past the last LED have no effect
        if (last < slpd_pkg::LED_COUNT) pred_leds[last] = 1'b0;
        if (nxt < slpd_pkg::LED_COUNT) pred_leds[nxt] = ~pred_leds[nxt];
        pred_rounds = pred_rounds + 8'd1;
      end
      if (pred_rounds == pred_round_goal) begin
        pred_leds[0] = 1'b0;
        pred_rounds = '0;
        r.done = 1'b1;
      end
    end else if (mode == slpd_pkg::MODE_ERROR) begin
      if (ph == 0) pred_leds = ~pred_leds;
    end else if (mode == slpd_pkg::MODE_READY) begin
      // new targets are only latched; unchanged ones are applied
      if (targets != pred_latched) begin
        pred_latched = targets;
      end else begin
        blink = ph < (pred_cycle_len >> 1);
        for (int i = 0; i < slpd_pkg::LED_COUNT; i++) begin
          code = (i < slpd_pkg::TARGET_LEDS) ?
                 pred_latched[slpd_pkg::CODE_W*i +: slpd_pkg::CODE_W] :
                 slpd_pkg::CODE_OFF;
          case (code)
            slpd_pkg::CODE_ON:    pred_leds[i] = 1'b1;
            slpd_pkg::CODE_OFF:   pred_leds[i] = 1'b0;
            slpd_pkg::CODE_BLINK: pred_leds[i] = blink;
            default: ;
          endcase
        end
      end
    end
    r.levels = pred_leds;
    return r;
  endfunction

  // Offer one tick after a random gap and hold it until the transfer
  task automatic send_tick(input logic [slpd_pkg::MODE_W-1:0] mode,
                           input logic [slpd_pkg::TARGET_W-1:0] targets);
    int gap;
    gap = sender_eager ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_led_targets <= targets;
    do @(posedge clk); while (in_stall);
    levels_due.push_back(advance_leds(mode, targets));
    tick_count++;
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain;
    in_valid <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write; only called with the block drained, valid stays high
  task automatic write_reg(input logic [slpd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [slpd_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      slpd_pkg::CFG_CYCLE_LENGTH:  pred_cycle_len  = data;
      slpd_pkg::CFG_ROUNDS_TARGET: pred_round_goal = data;
      slpd_pkg::CFG_CHASE_LENGTH:  pred_chase_len  = data[slpd_pkg::CHASE_W-1:0];
      default: ;
    endcase
    cfg_count++;
  endtask

  task automatic apply_setting(input logic [7:0] cyc, input logic [7:0] goal,
                               input logic [7:0] chase);
    drain();
    write_reg(slpd_pkg::CFG_CYCLE_LENGTH, cyc);
    write_reg(slpd_pkg::CFG_ROUNDS_TARGET, goal);
    write_reg(slpd_pkg::CFG_CHASE_LENGTH, chase);
    cfg_valid <= 1'b0;
  endtask

  // Random ticks; sync_pct sets the share of chase ticks
  task automatic run_random_ticks(input int count, input int sync_pct);
    int                            pick;
    logic [31:0]                   rnd;
    logic [slpd_pkg::MODE_W-1:0]   m;
    logic [slpd_pkg::TARGET_W-1:0] t;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      rnd = $urandom;
      t = rnd[slpd_pkg::TARGET_W-1:0];
      if (pick < sync_pct) begin
        m = $urandom_range(0, 1) ? slpd_pkg::MODE_SYNC : slpd_pkg::MODE_PARTIAL;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 45)      m = slpd_pkg::MODE_READY;
        else if (pick < 60) m = slpd_pkg::MODE_ERROR;
        else if (pick < 72) m = slpd_pkg::MODE_RESET;
        else if (pick < 84) m = slpd_pkg::MODE_IDLE;
        else if (pick < 92) m = MODE_SPARE6;
        else                m = MODE_SPARE7;
      end
      // ready ticks mostly repeat targets so they get applied
      if (m == slpd_pkg::MODE_READY) begin
        if ($urandom_range(0, 6) == 0) begin
          if ($urandom_range(0, 3) == 0) begin
            rnd = $urandom_range(0, 3);
            ready_pattern = {slpd_pkg::TARGET_LEDS{rnd[slpd_pkg::CODE_W-1:0]}};
          end else begin
            rnd = $urandom;
            ready_pattern = rnd[slpd_pkg::TARGET_W-1:0];
          end
        end
        t = ready_pattern;
      end
      if ($urandom_range(0, 19) == 0) sender_eager = !sender_eager;
      send_tick(m, t);
    end
  endtask

  // Every mode and target code at least once at the reset settings
  task automatic test_directed_modes;
    send_tick(slpd_pkg::MODE_RESET, '0);
    send_tick(slpd_pkg::MODE_IDLE, '1);
    send_tick(MODE_SPARE6, '0);
    send_tick(MODE_SPARE7, '1);
    send_tick(slpd_pkg::MODE_READY, 20'h55555);
    send_tick(slpd_pkg::MODE_READY, 20'h55555);
    send_tick(slpd_pkg::MODE_READY, 20'hFFFFF);
    send_tick(slpd_pkg::MODE_READY, 20'hFFFFF);
    send_tick(slpd_pkg::MODE_READY, 20'hAAAAA);
    send_tick(slpd_pkg::MODE_READY, 20'hAAAAA);
    send_tick(slpd_pkg::MODE_READY, 20'hAAAAA);
    send_tick(slpd_pkg::MODE_READY, 20'h00000);
    send_tick(slpd_pkg::MODE_READY, 20'h00000);
    for (int k = 0; k < 4; k++) send_tick(slpd_pkg::MODE_ERROR, '0);
    for (int k = 0; k < 6; k++) send_tick(slpd_pkg::MODE_SYNC, '1);
    for (int k = 0; k < 2; k++) send_tick(slpd_pkg::MODE_PARTIAL, '0);
  endtask

  // Register sweep: extremes, zero lengths, chase past the LEDs
  task automatic test_setting_sweep;
    run_random_ticks(40, 40);
    // one round per tick with a zero goal: the round counter must wrap
    apply_setting(8'd1, 8'd0, 8'd1);
    run_random_ticks(260, 100);
    apply_setting(8'd255, 8'd255, 8'd15);
    run_random_ticks(15, 40);
    apply_setting(8'd0, 8'd0, 8'd0);
    run_random_ticks(15, 50);
    apply_setting(8'd3, 8'd2, 8'd4);
    run_random_ticks(15, 50);
    apply_setting(8'd2, 8'd5, 8'd12);
    run_random_ticks(15, 60);
    apply_setting(8'd4, 8'd3, 8'd10);
    run_random_ticks(15, 40);
  endtask

  // Long receiver hold-off with the sender pushing, then a full pause
  task automatic test_backpressure;
    apply_setting(8'd2, 8'd1, 8'd15);
    sender_eager = 1'b1;
    hold_cycles  = 60;
    run_random_ticks(20, 50);
    drain();
    sender_eager = 1'b0;
    run_random_ticks(20, 50);
  endtask

  // Receiver: random stalls, eager stretches and requested hold-offs
  initial begin
    int n;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) receiver_eager = !receiver_eager;
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end else begin
        n = receiver_eager ? 0 : $urandom_range(0, 15);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare each transferred result with the oldest expectation
  always @(posedge clk) begin
    led_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      result_count++;
      if (out_sync_done) done_count++;
      if (levels_due.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("%0t: result with nothing expected: levels=%h done=%b",
                   $time, out_led_levels, out_sync_done);
      end else begin
        exp_r = levels_due.pop_front();
        if (out_led_levels !== exp_r.levels || out_sync_done !== exp_r.done) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display("%0t: mismatch: levels exp=%h got=%h, done exp=%b got=%b",
                     $time, exp_r.levels, out_led_levels, exp_r.done, out_sync_done);
        end
      end
    end
  end

  // Main sequence
  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_mode        <= slpd_pkg::MODE_RESET;
    in_led_targets <= '0;
    cfg_valid      <= 1'b0;
    cfg_index      <= slpd_pkg::CFG_CYCLE_LENGTH;
    cfg_data       <= '0;
    fault_count     = 0;
    tick_count      = 0;
    result_count    = 0;
    done_count      = 0;
    cfg_count       = 0;
    hold_cycles     = 0;
    sender_eager    = 1'b0;
    receiver_eager  = 1'b0;
    ready_pattern   = '0;
    pred_phase      = '0;
    pred_rounds     = '0;
    pred_chase      = '0;
    pred_leds       = '0;
    pred_latched    = '0;
    pred_cycle_len  = slpd_pkg::CYCLE_LENGTH_RST;
    pred_round_goal = slpd_pkg::ROUNDS_TARGET_RST;
    pred_chase_len  = slpd_pkg::CHASE_LENGTH_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_modes();
    test_setting_sweep();
    test_backpressure();
    drain();
    repeat (8) @(posedge clk);

    if (levels_due.size() != 0) begin
      fault_count++;
      $display("%0d expected results never arrived", levels_due.size());
    end
    $display("covered %0d ticks, %0d results, %0d done pulses, %0d register writes",
             tick_count, result_count, done_count, cfg_count);
    $display("all modes and target codes, zero and full lengths, long output hold-off");
    if (fault_count == 0) begin
      $display("status_led_pattern_driver_top_tb: done, clean");
    end else begin
      $display("%0d failures", fault_count);
      $display("status_led_pattern_driver_top_tb: done, errors");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #400000;
    $display("timeout with %0d results outstanding", levels_due.size());
    $display("status_led_pattern_driver_top_tb: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/slpd_pkg.sv
hw/rtl/slpd_rem.sv
hw/rtl/slpd_lane.sv
hw/rtl/status_led_pattern_driver_top.sv
verif/status_led_pattern_driver_top_tb.sv
